// ===== sv/dds_pkg.sv =====
package dds_pkg;

  localparam int PHASE_BITS  = 32;
  localparam int TABLE_DEPTH = 256;
  localparam int ROM_AW      = $clog2(TABLE_DEPTH);
  localparam int IDX_W       = (ROM_AW < 8) ? ROM_AW : 8;

  localparam logic [1:0] KIND_TICK   = 2'd0;
  localparam logic [1:0] KIND_PTR    = 2'd1;
  localparam logic [1:0] KIND_WRITE  = 2'd2;
  localparam logic [1:0] KIND_READ   = 2'd3;

  localparam logic [7:0] REG_STEP3   = 8'd3;
  localparam logic [7:0] REG_CTRL    = 8'd4;
  localparam logic [7:0] REG_ADC_HI  = 8'd5;

  localparam logic [7:0]            MIDSCALE    = 8'h80;
  localparam logic [7:0]            LEVEL_RESET = 8'h20;
  localparam logic [PHASE_BITS-1:0] STEP_RESET  = PHASE_BITS'(32'h079D5157);

  typedef logic [7:0] rom_t [TABLE_DEPTH];

  localparam rom_t SINE_ROM = '{
    8'h80, 8'h83, 8'h86, 8'h89, 8'h8c, 8'h8f, 8'h92, 8'h95,
    8'h98, 8'h9c, 8'h9f, 8'ha2, 8'ha5, 8'ha8, 8'hab, 8'hae,
    8'hb0, 8'hb3, 8'hb6, 8'hb9, 8'hbc, 8'hbf, 8'hc1, 8'hc4,
    8'hc7, 8'hc9, 8'hcc, 8'hce, 8'hd1, 8'hd3, 8'hd5, 8'hd8,
    8'hda, 8'hdc, 8'hde, 8'he0, 8'he2, 8'he4, 8'he6, 8'he8,
    8'hea, 8'hec, 8'hed, 8'hef, 8'hf0, 8'hf2, 8'hf3, 8'hf5,
    8'hf6, 8'hf7, 8'hf8, 8'hf9, 8'hfa, 8'hfb, 8'hfc, 8'hfc,
    8'hfd, 8'hfe, 8'hfe, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
    8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hfe, 8'hfe,
    8'hfd, 8'hfc, 8'hfc, 8'hfb, 8'hfa, 8'hf9, 8'hf8, 8'hf7,
    8'hf6, 8'hf5, 8'hf3, 8'hf2, 8'hf0, 8'hef, 8'hed, 8'hec,
    8'hea, 8'he8, 8'he6, 8'he4, 8'he2, 8'he0, 8'hde, 8'hdc,
    8'hda, 8'hd8, 8'hd5, 8'hd3, 8'hd1, 8'hce, 8'hcc, 8'hc9,
    8'hc7, 8'hc4, 8'hc1, 8'hbf, 8'hbc, 8'hb9, 8'hb6, 8'hb3,
    8'hb0, 8'hae, 8'hab, 8'ha8, 8'ha5, 8'ha2, 8'h9f, 8'h9c,
    8'h98, 8'h95, 8'h92, 8'h8f, 8'h8c, 8'h89, 8'h86, 8'h83,
    8'h80, 8'h7c, 8'h79, 8'h76, 8'h73, 8'h70, 8'h6d, 8'h6a,
    8'h67, 8'h63, 8'h60, 8'h5d, 8'h5a, 8'h57, 8'h54, 8'h51,
    8'h4f, 8'h4c, 8'h49, 8'h46, 8'h43, 8'h40, 8'h3e, 8'h3b,
    8'h38, 8'h36, 8'h33, 8'h31, 8'h2e, 8'h2c, 8'h2a, 8'h27,
    8'h25, 8'h23, 8'h21, 8'h1f, 8'h1d, 8'h1b, 8'h19, 8'h17,
    8'h15, 8'h13, 8'h12, 8'h10, 8'h0f, 8'h0d, 8'h0c, 8'h0a,
    8'h09, 8'h08, 8'h07, 8'h06, 8'h05, 8'h04, 8'h03, 8'h03,
    8'h02, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01,
    8'h02, 8'h03, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08,
    8'h09, 8'h0a, 8'h0c, 8'h0d, 8'h0f, 8'h10, 8'h12, 8'h13,
    8'h15, 8'h17, 8'h19, 8'h1b, 8'h1d, 8'h1f, 8'h21, 8'h23,
    8'h25, 8'h27, 8'h2a, 8'h2c, 8'h2e, 8'h31, 8'h33, 8'h36,
    8'h38, 8'h3b, 8'h3e, 8'h40, 8'h43, 8'h46, 8'h49, 8'h4c,
    8'h4f, 8'h51, 8'h54, 8'h57, 8'h5a, 8'h5d, 8'h60, 8'h63,
    8'h67, 8'h6a, 8'h6d, 8'h70, 8'h73, 8'h76, 8'h79, 8'h7c
  };

  typedef struct packed {
    logic       upd;
    logic       mid;
    logic [7:0] rd;
  } s1_t;

endpackage

// ===== sv/dds_sine_generator_with_byte_registers_unit.sv =====
// Result path: request accept, then ROM read with its stage register, then output register.
// Throughput: one request per cycle while the output is not stalled; the sine ROM
// read port is the only multi-cycle element, pipelined with one stage register.
// Reset (rst, synchronous): pipeline empty, phase 0, step 0x079D5157,
// running, pointer 0, ADC latch 0, level 0x20.
module dds_sine_generator_with_byte_registers_unit
  import dds_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] kind,
  input  logic [7:0] data,
  input  logic [9:0] adc_sample,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] level,
  output logic [7:0] read_data
);

  logic [PHASE_BITS-1:0] phase_acc, phase_acc_next;
  logic [PHASE_BITS-1:0] phase_step, phase_step_next;
  logic                  stopped, stopped_next;
  logic [7:0]            reg_pointer, reg_pointer_next;
  logic [9:0]            adc_latch, adc_latch_next;
  logic [7:0]            level_reg, level_next;

  logic       s1_valid;
  s1_t        s1, s1_next;
  logic       advance, accept;
  logic [7:0] rom_q;
  logic [7:0] rom_idx;
  logic [1:0] byte_sel;

  assign advance  = !out_valid || out_ready;
  assign in_ready = !s1_valid || advance;
  assign accept   = in_valid && in_ready;
  assign byte_sel = reg_pointer[1:0];

  always_comb begin
    phase_acc_next   = phase_acc;
    phase_step_next  = phase_step;
    stopped_next     = stopped;
    reg_pointer_next = reg_pointer;
    adc_latch_next   = adc_latch;
    s1_next          = '0;
    case (kind)
      KIND_TICK: begin
        if (stopped) begin
          s1_next.mid = 1'b1;
        end else begin
          phase_acc_next = phase_acc + phase_step;
          s1_next.upd    = 1'b1;
        end
      end
      KIND_PTR: begin
        reg_pointer_next = data;
      end
      KIND_WRITE: begin
        if (reg_pointer <= REG_STEP3) begin
          phase_step_next[8*byte_sel +: 8] = data;
        end else if (reg_pointer == REG_CTRL) begin
          stopped_next = data[7];
        end
        reg_pointer_next = reg_pointer + 8'd1;
      end
      KIND_READ: begin
        if (reg_pointer <= REG_STEP3) begin
          s1_next.rd = phase_step[8*byte_sel +: 8];
        end else if (reg_pointer == REG_CTRL) begin
          adc_latch_next = adc_sample;
          s1_next.rd     = adc_sample[7:0];
        end else if (reg_pointer == REG_ADC_HI) begin
          s1_next.rd = {6'd0, adc_latch[9:8]};
        end
        reg_pointer_next = reg_pointer + 8'd1;
      end
      default: begin
      end
    endcase
  end

  assign rom_idx = phase_acc_next[PHASE_BITS-1 -: 8];

  dds_rom u_rom (
    .clk  (clk),
    .en   (accept),
    .addr (ROM_AW'(rom_idx[IDX_W-1:0])),
    .q    (rom_q)
  );

  always_comb begin
    level_next = level_reg;
    if (s1.upd) begin
      level_next = rom_q;
    end else if (s1.mid) begin
      level_next = MIDSCALE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc   <= '0;
      phase_step  <= STEP_RESET;
      stopped     <= 1'b0;
      reg_pointer <= '0;
      adc_latch   <= '0;
      level_reg   <= LEVEL_RESET;
      s1_valid    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (accept) begin
        phase_acc   <= phase_acc_next;
        phase_step  <= phase_step_next;
        stopped     <= stopped_next;
        reg_pointer <= reg_pointer_next;
        adc_latch   <= adc_latch_next;
      end
      if (advance) begin
        out_valid <= s1_valid;
        if (s1_valid) begin
          level_reg <= level_next;
        end
      end
      if (in_ready) begin
        s1_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= s1_next;
    end
    if (advance && s1_valid) begin
      level     <= level_next;
      read_data <= s1.rd;
    end
  end

endmodule

// ===== sv/dds_rom.sv =====
module dds_rom
  import dds_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [ROM_AW-1:0] addr,
  output logic [7:0]        q
);

  always_ff @(posedge clk) begin
    if (en) begin
      q <= SINE_ROM[addr];
    end
  end

endmodule

// ===== sv/dds_checker.sv =====
module dds_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] level,
  input logic [7:0] read_data
);

  logic [1:0] inflight;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(level) && $stable(read_data))
    else $error("stalled result changed");

  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("not ready with empty output");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    inflight <= 2'd2 && (!out_valid || inflight != 2'd0))
    else $error("request count mismatch");

endmodule

bind dds_sine_generator_with_byte_registers_unit dds_checker u_dds_checker (.*);

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import dds_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int ITEM_GOAL   = 1350;
  localparam int HOLD_CYCLES = 300;

  localparam logic [7:0] SINE_LUT [256] = '{
    8'h80, 8'h83, 8'h86, 8'h89, 8'h8c, 8'h8f, 8'h92, 8'h95,
    8'h98, 8'h9c, 8'h9f, 8'ha2, 8'ha5, 8'ha8, 8'hab, 8'hae,
    8'hb0, 8'hb3, 8'hb6, 8'hb9, 8'hbc, 8'hbf, 8'hc1, 8'hc4,
    8'hc7, 8'hc9, 8'hcc, 8'hce, 8'hd1, 8'hd3, 8'hd5, 8'hd8,
    8'hda, 8'hdc, 8'hde, 8'he0, 8'he2, 8'he4, 8'he6, 8'he8,
    8'hea, 8'hec, 8'hed, 8'hef, 8'hf0, 8'hf2, 8'hf3, 8'hf5,
    8'hf6, 8'hf7, 8'hf8, 8'hf9, 8'hfa, 8'hfb, 8'hfc, 8'hfc,
    8'hfd, 8'hfe, 8'hfe, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
    8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hfe, 8'hfe,
    8'hfd, 8'hfc, 8'hfc, 8'hfb, 8'hfa, 8'hf9, 8'hf8, 8'hf7,
    8'hf6, 8'hf5, 8'hf3, 8'hf2, 8'hf0, 8'hef, 8'hed, 8'hec,
    8'hea, 8'he8, 8'he6, 8'he4, 8'he2, 8'he0, 8'hde, 8'hdc,
    8'hda, 8'hd8, 8'hd5, 8'hd3, 8'hd1, 8'hce, 8'hcc, 8'hc9,
    8'hc7, 8'hc4, 8'hc1, 8'hbf, 8'hbc, 8'hb9, 8'hb6, 8'hb3,
    8'hb0, 8'hae, 8'hab, 8'ha8, 8'ha5, 8'ha2, 8'h9f, 8'h9c,
    8'h98, 8'h95, 8'h92, 8'h8f, 8'h8c, 8'h89, 8'h86, 8'h83,
    8'h80, 8'h7c, 8'h79, 8'h76, 8'h73, 8'h70, 8'h6d, 8'h6a,
    8'h67, 8'h63, 8'h60, 8'h5d, 8'h5a, 8'h57, 8'h54, 8'h51,
    8'h4f, 8'h4c, 8'h49, 8'h46, 8'h43, 8'h40, 8'h3e, 8'h3b,
    8'h38, 8'h36, 8'h33, 8'h31, 8'h2e, 8'h2c, 8'h2a, 8'h27,
    8'h25, 8'h23, 8'h21, 8'h1f, 8'h1d, 8'h1b, 8'h19, 8'h17,
    8'h15, 8'h13, 8'h12, 8'h10, 8'h0f, 8'h0d, 8'h0c, 8'h0a,
    8'h09, 8'h08, 8'h07, 8'h06, 8'h05, 8'h04, 8'h03, 8'h03,
    8'h02, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01,
    8'h02, 8'h03, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08,
    8'h09, 8'h0a, 8'h0c, 8'h0d, 8'h0f, 8'h10, 8'h12, 8'h13,
    8'h15, 8'h17, 8'h19, 8'h1b, 8'h1d, 8'h1f, 8'h21, 8'h23,
    8'h25, 8'h27, 8'h2a, 8'h2c, 8'h2e, 8'h31, 8'h33, 8'h36,
    8'h38, 8'h3b, 8'h3e, 8'h40, 8'h43, 8'h46, 8'h49, 8'h4c,
    8'h4f, 8'h51, 8'h54, 8'h57, 8'h5a, 8'h5d, 8'h60, 8'h63,
    8'h67, 8'h6a, 8'h6d, 8'h70, 8'h73, 8'h76, 8'h79, 8'h7c
  };

  typedef struct packed {
    logic [7:0] lvl;
    logic [7:0] rd;
  } sine_out_t;

  typedef enum int {RX_OPEN, RX_HALF, RX_MOSTLY, RX_SPARSE} rx_mode_t;

  logic       clk        = 1'b0;
  logic       rst        = 1'b1;
  logic       in_valid   = 1'b0;
  logic       in_ready;
  logic [1:0] kind       = KIND_TICK;
  logic [7:0] data       = '0;
  logic [9:0] adc_sample = '0;
  logic       out_valid;
  logic       out_ready  = 1'b0;
  logic [7:0] level;
  logic [7:0] read_data;

  logic [31:0] gen_phase;
  logic [31:0] gen_step;
  logic        gen_stopped;
  logic [7:0]  gen_ptr;
  logic [9:0]  gen_adc;
  logic [7:0]  gen_level;

  sine_out_t expected_outputs[$];
  int        req_accepted = 0;
  int        items_sent   = 0;
  int        burst_left   = 0;
  int        fail_count   = 0;
  int        idle_cycles  = 0;
  int        rx_cycle     = 0;
  int        hold_left    = 0;
  bit        hold_off_req = 1'b0;

  dds_sine_generator_with_byte_registers_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .data      (data),
    .adc_sample(adc_sample),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .level     (level),
    .read_data (read_data)
  );

  always #6 clk = ~clk;

  function automatic void reset_generator();
    gen_phase   = '0;
    gen_step    = 32'h079D5157;
    gen_stopped = 1'b0;
    gen_ptr     = '0;
    gen_adc     = '0;
    gen_level   = 8'h20;
  endfunction

  function automatic sine_out_t next_sine_output(input logic [1:0] k, input logic [7:0] d,
                                                 input logic [9:0] s);
    sine_out_t res;
    res.rd = '0;
    case (k)
      KIND_TICK: begin
        if (gen_stopped) begin
          gen_level = 8'h80;
        end else begin
          gen_phase = gen_phase + gen_step;
          gen_level = SINE_LUT[gen_phase[31:24]];
        end
      end
      KIND_PTR: gen_ptr = d;
      KIND_WRITE: begin
        if (gen_ptr <= REG_STEP3) begin
          gen_step[8*gen_ptr[1:0] +: 8] = d;
        end else if (gen_ptr == REG_CTRL) begin
          gen_stopped = d[7];
        end
        gen_ptr = gen_ptr + 8'd1;
      end
      default: begin
        if (gen_ptr <= REG_STEP3) begin
          res.rd = gen_step[8*gen_ptr[1:0] +: 8];
        end else if (gen_ptr == REG_CTRL) begin
          gen_adc = s;
          res.rd  = s[7:0];
        end else if (gen_ptr == REG_ADC_HI) begin
          res.rd = {6'b0, gen_adc[9:8]};
        end
        gen_ptr = gen_ptr + 8'd1;
      end
    endcase
    res.lvl = gen_level;
    return res;
  endfunction

  task automatic note_mismatch(input string what, input logic [7:0] want, input logic [7:0] got);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t: %s mismatch: expected %02h, got %02h", $realtime, what, want, got);
    end
  endtask

  // predictor and result check
  always @(posedge clk) begin
    sine_out_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        req_accepted++;
        expected_outputs.push_back(next_sine_output(kind, data, adc_sample));
      end
      if (out_valid && out_ready) begin
        if (expected_outputs.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("%0t: result with no request pending", $realtime);
          end
        end else begin
          want = expected_outputs.pop_front();
          if (level !== want.lvl) note_mismatch("level", want.lvl, level);
          if (read_data !== want.rd) note_mismatch("read_data", want.rd, read_data);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Timeout: no progress for %0d cycles", STALL_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  always @(negedge clk) begin
    rx_mode_t mode;
    mode = rx_mode_t'((rx_cycle / 97) % 4);
    if (hold_off_req) begin
      hold_left    = HOLD_CYCLES;
      hold_off_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case (mode)
        RX_OPEN:   out_ready <= 1'b1;
        RX_HALF:   out_ready <= 1'($urandom_range(0, 1));
        RX_MOSTLY: out_ready <= ($urandom_range(0, 9) != 0);
        default:   out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
    rx_cycle++;
  end

  task automatic send_req(input logic [1:0] k, input logic [7:0] d, input logic [9:0] s);
    int target;
    target = req_accepted + 1;
    in_valid   <= 1'b1;
    kind       <= k;
    data       <= d;
    adc_sample <= s;
    items_sent++;
    do @(negedge clk); while (req_accepted < target);
  endtask

  task automatic offer_req(input logic [1:0] k, input logic [7:0] d, input logic [9:0] s);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      burst_left = $urandom_range(1, 20);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    send_req(k, d, s);
  endtask

  function automatic logic [7:0] pick_pointer();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 8'($urandom_range(0, 6));
    if (r < 85) return 8'($urandom_range(250, 255));
    return 8'($urandom);
  endfunction

  task automatic test_reset_values();
    send_req(KIND_TICK, 8'h00, 10'h000);
    repeat (4) send_req(KIND_READ, 8'h00, 10'h000);
    send_req(KIND_READ, 8'hff, 10'h3ff);
    send_req(KIND_READ, 8'h00, 10'h000);
  endtask

  task automatic test_step_extremes();
    send_req(KIND_PTR, 8'h00, 10'h000);
    repeat (4) send_req(KIND_WRITE, 8'hff, 10'h3ff);
    send_req(KIND_TICK, 8'h00, 10'h000);
    send_req(KIND_PTR, 8'h00, 10'h000);
    repeat (4) send_req(KIND_WRITE, 8'h00, 10'h000);
  endtask

  task automatic test_stop_flag();
    send_req(KIND_PTR, REG_STEP3, 10'h000);
    send_req(KIND_WRITE, 8'h40, 10'h000);
    send_req(KIND_WRITE, 8'h80, 10'h000);
    send_req(KIND_TICK, 8'h00, 10'h000);
    send_req(KIND_PTR, REG_CTRL, 10'h000);
    send_req(KIND_WRITE, 8'h7f, 10'h000);
    send_req(KIND_TICK, 8'h00, 10'h000);
  endtask

  task automatic test_pointer_wrap();
    send_req(KIND_PTR, 8'hff, 10'h000);
    send_req(KIND_READ, 8'h00, 10'h000);
    send_req(KIND_PTR, 8'hff, 10'h000);
    send_req(KIND_WRITE, 8'haa, 10'h000);
    send_req(KIND_READ, 8'h00, 10'h000);
  endtask

  // receiver holds off while requests keep coming, so the block backs up
  task automatic test_backpressure();
    hold_off_req = 1'b1;
    repeat (40) send_req(2'($urandom), 8'($urandom), 10'($urandom));
  endtask

  task automatic test_random_traffic(input int goal);
    int         r;
    int         n;
    logic [7:0] p;
    logic [7:0] d;
    while (items_sent < goal) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        n = $urandom_range(1, 12);
        repeat (n) offer_req(KIND_TICK, 8'($urandom), 10'($urandom));
      end else if (r < 95) begin
        p = pick_pointer();
        offer_req(KIND_PTR, p, 10'($urandom));
        n = $urandom_range(1, 6);
        repeat (n) begin
          d = 8'($urandom);
          if (r < 75) begin
            if (p == REG_CTRL) d[7] = ($urandom_range(0, 3) == 0);
            offer_req(KIND_WRITE, d, 10'($urandom));
          end else begin
            offer_req(KIND_READ, d, 10'($urandom));
          end
          p = p + 8'd1;
        end
      end else begin
        offer_req(2'($urandom), 8'($urandom), 10'($urandom));
      end
    end
  endtask

  task automatic finish_run();
    in_valid <= 1'b0;
    while (expected_outputs.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  endtask

  initial begin
    reset_generator();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_values();
    test_step_extremes();
    test_stop_flag();
    test_pointer_wrap();
    test_backpressure();
    test_random_traffic(ITEM_GOAL);
    finish_run();
  end

endmodule
